### sv/line_centroid_analog_core_assert.svh
// Assertion macros used by the line centroid top level.
`ifndef LINE_CENTROID_ANALOG_CORE_ASSERT_SVH
`define LINE_CENTROID_ANALOG_CORE_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define LCA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define LCA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lca_pkg.sv
// Shared constants, types and functions of the line centroid core.
`default_nettype none

package lca_pkg;

    localparam int SENSOR_COUNT   = 8;
    localparam int SAMPLE_W       = 8;
    localparam int POS_W          = 13;
    localparam int CONF_W         = 7;
    localparam int SUM_W          = 11;
    localparam int PROD_W         = 21;
    localparam int WSUM_W         = 23;
    localparam int MAG_W          = 22;
    localparam int Q_W            = 12;
    localparam int BITS_PER_STAGE = 2;
    localparam int ITER_STAGES    = Q_W / BITS_PER_STAGE;
    localparam int DIV_STAGES     = 1 + ITER_STAGES;
    localparam int PIPE_STAGES    = 3 + DIV_STAGES;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    localparam logic [1:0] REG_DARK_LINE        = 2'd0;
    localparam logic [1:0] REG_SIGNAL_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_MIN_TOTAL        = 2'd2;

    localparam logic                DARK_LINE_RST = 1'b1;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 8'd128;
    localparam logic [SUM_W-1:0]    MIN_TOTAL_RST = 11'd100;

    localparam logic [Q_W-1:0]          POS_LIMIT      = 12'd3500;
    localparam logic signed [POS_W-1:0] POS_LIMIT_S    = 13'sd3500;
    localparam logic [CONF_W-1:0]       CONF_MAX       = 7'd100;
    localparam logic [SUM_W-1:0]        FULL_SCALE_SUM = 11'd1020;
    // floor(sum*100/1020) = floor(sum*25705 / 2^18) for sum <= 1020
    localparam logic [14:0]             CONF_MUL       = 15'd25705;
    localparam int                      CONF_SHIFT     = 18;

    typedef struct packed {
        logic [SUM_W-1:0]         sum;
        logic signed [WSUM_W-1:0] wsum;
        logic [SENSOR_COUNT-1:0]  mask;
    } lca_merge_t;

    typedef struct packed {
        logic                    est_valid;
        logic                    nonzero;
        logic                    neg;
        logic [CONF_W-1:0]       conf;
        logic [SENSOR_COUNT-1:0] mask;
        logic [SUM_W-1:0]        divisor;
    } lca_side_t;

    function automatic logic signed [POS_W-1:0] lane_weight(input int idx);
        return POS_W'(-3500 + 1000 * idx);
    endfunction

endpackage

`default_nettype wire

### sv/line_centroid_analog_core.sv
// Top level of the line centroid core: lanes, merge, divider, output register.
// Throughput: one request per cycle unless m_ready stalls the output (bubbles collapse
// under stall); lane stage, merge stage, 7-stage divider (prep plus 6 radix-4 steps)
// and output register are pipelined.
// Reset (aresetn low at a clock edge) empties the pipeline and restores the
// configuration defaults: dark_line 1, signal_threshold 128, min_total 100.
`default_nettype none

`include "line_centroid_analog_core_assert.svh"

module line_centroid_analog_core
    import lca_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ADDR_W-1:0]          paddr,
    input  wire logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]               prdata,
    output logic                            pready,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [SAMPLE_W-1:0]        s_sample_0,
    input  wire logic [SAMPLE_W-1:0]        s_sample_1,
    input  wire logic [SAMPLE_W-1:0]        s_sample_2,
    input  wire logic [SAMPLE_W-1:0]        s_sample_3,
    input  wire logic [SAMPLE_W-1:0]        s_sample_4,
    input  wire logic [SAMPLE_W-1:0]        s_sample_5,
    input  wire logic [SAMPLE_W-1:0]        s_sample_6,
    input  wire logic [SAMPLE_W-1:0]        s_sample_7,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_estimate_valid,
    output logic signed [POS_W-1:0]         m_line_position,
    output logic [CONF_W-1:0]               m_confidence_pct,
    output logic [SENSOR_COUNT-1:0]         m_sensor_mask
);

    localparam int LAST = PIPE_STAGES - 1;

    logic                    dark_line_reg;
    logic [SAMPLE_W-1:0]     threshold_reg;
    logic [SUM_W-1:0]        min_total_reg;
    logic                    cfg_wr;

    logic [PIPE_STAGES-1:0]  vld_reg, vld_next;
    logic [PIPE_STAGES-1:0]  en;

    logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] samples;
    logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] lane_sig;
    logic [SENSOR_COUNT-1:0]               lane_act;
    logic [SENSOR_COUNT-1:0][PROD_W-1:0]   lane_prod;

    lca_merge_t              merged;
    lca_side_t               side;
    logic [Q_W-1:0]          quot;
    logic [Q_W-1:0]          quot_clamped;
    logic signed [POS_W-1:0] pos_mag;

    logic                    est_valid_reg, est_valid_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic [CONF_W-1:0]       conf_reg;
    logic [SENSOR_COUNT-1:0] mask_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_line_reg <= DARK_LINE_RST;
            threshold_reg <= THRESHOLD_RST;
            min_total_reg <= MIN_TOTAL_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DARK_LINE:        dark_line_reg <= pwdata[0];
                REG_SIGNAL_THRESHOLD: threshold_reg <= pwdata[SAMPLE_W-1:0];
                REG_MIN_TOTAL:        min_total_reg <= pwdata[SUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DARK_LINE:        prdata = DATA_W'(dark_line_reg);
            REG_SIGNAL_THRESHOLD: prdata = DATA_W'(threshold_reg);
            REG_MIN_TOTAL:        prdata = DATA_W'(min_total_reg);
            default:              prdata = '0;
        endcase
    end

    // pipeline occupancy; a stage advances when empty or when its successor advances
    always_comb begin
        en[LAST] = !vld_reg[LAST] || m_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = en[0];

    assign samples[0] = s_sample_0;
    assign samples[1] = s_sample_1;
    assign samples[2] = s_sample_2;
    assign samples[3] = s_sample_3;
    assign samples[4] = s_sample_4;
    assign samples[5] = s_sample_5;
    assign samples[6] = s_sample_6;
    assign samples[7] = s_sample_7;

    for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
        lca_lane u_lane (
            .aclk      (aclk),
            .en        (en[0]),
            .dark_line (dark_line_reg),
            .threshold (threshold_reg),
            .weight    (lane_weight(i)),
            .sample    (samples[i]),
            .sig       (lane_sig[i]),
            .active    (lane_act[i]),
            .prod      (lane_prod[i])
        );
    end

    lca_merge u_merge (
        .aclk   (aclk),
        .en     (en[1]),
        .sig    (lane_sig),
        .act    (lane_act),
        .prod   (lane_prod),
        .merged (merged)
    );

    lca_div u_div (
        .aclk      (aclk),
        .en        (en[2 +: DIV_STAGES]),
        .merged    (merged),
        .min_total (min_total_reg),
        .side_out  (side),
        .quot      (quot)
    );

    // output stage: clamp, sign and gating
    always_comb begin
        quot_clamped   = (quot > POS_LIMIT) ? POS_LIMIT : quot;
        pos_mag        = $signed({1'b0, quot_clamped});
        est_valid_next = side.est_valid;
        if (!side.nonzero) begin
            pos_next = '0;
        end else if (side.neg) begin
            pos_next = -pos_mag;
        end else begin
            pos_next = pos_mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[LAST]) begin
            est_valid_reg <= est_valid_next;
            pos_reg       <= pos_next;
            conf_reg      <= side.conf;
            mask_reg      <= side.mask;
        end
    end

    assign m_valid          = vld_reg[LAST];
    assign m_estimate_valid = est_valid_reg;
    assign m_line_position  = pos_reg;
    assign m_confidence_pct = conf_reg;
    assign m_sensor_mask    = mask_reg;

    `LCA_ASSERT_IMP(a_invalid_zero, m_valid && !m_estimate_valid,
        m_line_position == '0 && m_confidence_pct == '0, "invalid estimate not zeroed")
    `LCA_ASSERT_IMP(a_conf_range, m_valid, m_confidence_pct <= CONF_MAX,
        "confidence above full scale")
    `LCA_ASSERT_IMP(a_pos_range, m_valid,
        m_line_position <= POS_LIMIT_S && m_line_position >= -POS_LIMIT_S,
        "position out of range")
    `LCA_ASSERT_IMP(a_empty_ready, !m_valid, s_ready, "empty output stage blocks input")
    `LCA_ASSERT_NXT(a_accept_lands, s_valid && s_ready, vld_reg[0],
        "accepted request lost at lane stage")

endmodule

`default_nettype wire

### sv/lca_lane.sv
// One sensor lane: inversion, threshold test and position-weighted product.
`default_nettype none

module lca_lane
    import lca_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic                       dark_line,
    input  wire logic [SAMPLE_W-1:0]        threshold,
    input  wire logic signed [POS_W-1:0]    weight,
    input  wire logic [SAMPLE_W-1:0]        sample,
    output logic [SAMPLE_W-1:0]             sig,
    output logic                            active,
    output logic [PROD_W-1:0]               prod
);

    logic [SAMPLE_W-1:0]              sig_reg, sig_next;
    logic                             active_reg, active_next;
    logic [PROD_W-1:0]                prod_reg, prod_next;
    logic signed [SAMPLE_W+POS_W:0]   prod_full;

    always_comb begin
        sig_next    = dark_line ? ~sample : sample;
        active_next = sig_next > threshold;
        prod_full   = $signed({1'b0, sig_next}) * weight;
        prod_next   = prod_full[PROD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sig_reg    <= sig_next;
            active_reg <= active_next;
            prod_reg   <= prod_next;
        end
    end

    assign sig    = sig_reg;
    assign active = active_reg;
    assign prod   = prod_reg;

endmodule

`default_nettype wire

### sv/lca_merge.sv
// Merge stage: sums the lane signals and weighted products, gathers the mask.
`default_nettype none

module lca_merge
    import lca_pkg::*;
(
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0]  sig,
    input  wire logic [SENSOR_COUNT-1:0]                act,
    input  wire logic [SENSOR_COUNT-1:0][PROD_W-1:0]    prod,
    output lca_merge_t                                  merged
);

    lca_merge_t               merged_reg, merged_next;
    logic [SUM_W-1:0]         sum_acc;
    logic signed [WSUM_W-1:0] w_acc;

    always_comb begin
        sum_acc = '0;
        w_acc   = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            sum_acc = sum_acc + SUM_W'(sig[i]);
            w_acc   = w_acc + WSUM_W'($signed(prod[i]));
        end
        merged_next.sum  = sum_acc;
        merged_next.wsum = w_acc;
        merged_next.mask = act;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            merged_reg <= merged_next;
        end
    end

    assign merged = merged_reg;

endmodule

`default_nettype wire

### sv/lca_div.sv
// Pipelined centroid divider: prep stage, then radix-4 restoring steps.
`default_nettype none

module lca_div
    import lca_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic [DIV_STAGES-1:0] en,
    input  wire lca_merge_t            merged,
    input  wire logic [SUM_W-1:0]      min_total,
    output lca_side_t                  side_out,
    output logic [Q_W-1:0]             quot
);

    logic [SUM_W-1:0]  rem_reg  [ITER_STAGES+1];
    logic [Q_W-1:0]    work_reg [ITER_STAGES+1];
    lca_side_t         side_reg [ITER_STAGES+1];

    logic [SUM_W-1:0]          rem_c  [1:ITER_STAGES];
    logic [Q_W-1:0]            work_c [1:ITER_STAGES];

    logic signed [WSUM_W-1:0]  mag_full;
    logic [MAG_W-1:0]          mag;
    logic [25:0]               conf_prod;
    lca_side_t                 side_next;

    // prep: magnitude, validity, confidence
    always_comb begin
        side_next.neg       = merged.wsum[WSUM_W-1];
        mag_full            = side_next.neg ? -merged.wsum : merged.wsum;
        mag                 = mag_full[MAG_W-1:0];
        side_next.est_valid = merged.sum >= min_total;
        side_next.nonzero   = side_next.est_valid && (merged.sum != '0);
        conf_prod           = 26'(merged.sum) * 26'(CONF_MUL);
        if (!side_next.nonzero) begin
            side_next.conf = '0;
        end else if (merged.sum > FULL_SCALE_SUM) begin
            side_next.conf = CONF_MAX;
        end else begin
            side_next.conf = conf_prod[CONF_SHIFT +: CONF_W];
        end
        side_next.mask    = merged.mask;
        side_next.divisor = merged.sum;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0]  <= SUM_W'(mag[MAG_W-1:Q_W]);
            work_reg[0] <= mag[Q_W-1:0];
            side_reg[0] <= side_next;
        end
    end

    for (genvar k = 1; k <= ITER_STAGES; k++) begin : g_step
        always_comb begin : p_step
            logic [SUM_W-1:0] r;
            logic [Q_W-1:0]   w;
            logic [SUM_W:0]   r2;
            r = rem_reg[k-1];
            w = work_reg[k-1];
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                r2 = {r, w[Q_W-1]};
                w  = {w[Q_W-2:0], 1'b0};
                if (r2 >= {1'b0, side_reg[k-1].divisor}) begin
                    r2   = r2 - {1'b0, side_reg[k-1].divisor};
                    w[0] = 1'b1;
                end
                r = r2[SUM_W-1:0];
            end
            rem_c[k]  = r;
            work_c[k] = w;
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k]  <= rem_c[k];
                work_reg[k] <= work_c[k];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign side_out = side_reg[ITER_STAGES];
    assign quot     = work_reg[ITER_STAGES];

endmodule

`default_nettype wire
